// File: hw/rtl/sip_pkg.sv
`default_nettype none
package sip_pkg;

  localparam int CoordWidth = 24;
  localparam int FracBits   = 8;
  localparam int TFracBits  = 16;

  typedef struct packed {
    logic signed [CoordWidth-1:0] seg1_start_x;
    logic signed [CoordWidth-1:0] seg1_start_y;
    logic signed [CoordWidth-1:0] seg1_end_x;
    logic signed [CoordWidth-1:0] seg1_end_y;
    logic signed [CoordWidth-1:0] seg2_start_x;
    logic signed [CoordWidth-1:0] seg2_start_y;
    logic signed [CoordWidth-1:0] seg2_end_x;
    logic signed [CoordWidth-1:0] seg2_end_y;
  } seg_in_t;

  typedef struct packed {
    logic                         hit;
    logic signed [CoordWidth-1:0] hit_x;
    logic signed [CoordWidth-1:0] hit_y;
  } seg_out_t;

endpackage
`default_nettype wire

// File: hw/rtl/segment_intersection_point.sv
`default_nettype none
// Pipeline: input capture, areas, hit decision, division with one quotient
// bit per division stage, multiply, output. Throughput: one
// pair per cycle; stall freezes the whole pipeline and the output register.
// Reset: rst clears all valid bits; data registers are not reset.
module segment_intersection_point #(
  parameter int T_FRAC_BITS = sip_pkg::TFracBits
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire sip_pkg::seg_in_t  in_data,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output sip_pkg::seg_out_t      out_data
);
  import sip_pkg::*;

  localparam int CW = CoordWidth;
  localparam int AW = 2 * CW + 4;
  localparam int NW = AW;
  localparam int NST = T_FRAC_BITS + 6;
  localparam int DW = CW + 1;
  localparam int MW = T_FRAC_BITS + DW;

  logic adv;
  logic [NST-1:0] vld;

  assign adv      = !out_valid || !out_stall;
  assign in_stall = !adv;
  assign out_valid = vld[NST-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[NST-2:0], in_valid};
    end
  end

  // stage 0: capture inputs
  seg_in_t s0;
  always_ff @(posedge clk) begin
    if (adv) s0 <= in_data;
  end

  // stages 1-2: areas; carry A and B-A alongside
  logic signed [AW-1:0] a1, a2, a3, a4;
  sip_area #(.CW(CW)) u_area (
    .clk(clk), .adv(adv),
    .ax(s0.seg1_start_x), .ay(s0.seg1_start_y),
    .bx(s0.seg1_end_x), .by(s0.seg1_end_y),
    .cx(s0.seg2_start_x), .cy(s0.seg2_start_y),
    .dx(s0.seg2_end_x), .dy(s0.seg2_end_y),
    .a1(a1), .a2(a2), .a3(a3), .a4(a4)
  );

  localparam int CL = T_FRAC_BITS + 3;
  logic signed [CW-1:0] cax [CL], cay [CL];
  logic signed [DW-1:0] cdx [CL], cdy [CL];
  always_ff @(posedge clk) begin
    if (adv) begin
      cax[0] <= s0.seg1_start_x;
      cay[0] <= s0.seg1_start_y;
      cdx[0] <= DW'(s0.seg1_end_x) - DW'(s0.seg1_start_x);
      cdy[0] <= DW'(s0.seg1_end_y) - DW'(s0.seg1_start_y);
      for (int i = 1; i < CL; i++) begin
        cax[i] <= cax[i-1]; cay[i] <= cay[i-1];
        cdx[i] <= cdx[i-1]; cdy[i] <= cdy[i-1];
      end
    end
  end
  // cax[1] and cdx[1] align with areas

  // stage 3: decide hit, form |a3| and |a3-a4|
  logic hit3;
  logic [NW-1:0] num3, den3;
  logic signed [AW-1:0] dd;
  logic o12, o34;
  always_comb begin
    o12 = (a1 != '0) && (a2 != '0) && (a1[AW-1] != a2[AW-1]);
    o34 = (a3 != '0) && (a4 != '0) && (a3[AW-1] != a4[AW-1]);
    dd  = a3 - a4;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      hit3 <= o12 && o34;
      num3 <= a3[AW-1] ? NW'(-a3) : NW'(a3);
      den3 <= dd[AW-1] ? NW'(-dd) : NW'(dd);
    end
  end

  // division stages
  logic [NW-1:0] nm [T_FRAC_BITS+1], dn [T_FRAC_BITS+1];
  logic [T_FRAC_BITS-1:0] qq [T_FRAC_BITS+1];
  logic [T_FRAC_BITS-1:0] hh;
  assign nm[0] = num3;
  assign dn[0] = den3;
  assign qq[0] = '0;
  for (genvar k = 0; k < T_FRAC_BITS; k++) begin : g_div
    sip_div_stage #(.NW(NW), .QW(T_FRAC_BITS)) u_st (
      .clk(clk), .adv(adv),
      .num_in(nm[k]), .den_in(dn[k]), .q_in(qq[k]),
      .num_out(nm[k+1]), .den_out(dn[k+1]), .q_out(qq[k+1])
    );
  end

  // hit flag travels beside the division stages
  always_ff @(posedge clk) begin
    if (adv) hh <= {hh[T_FRAC_BITS-2:0], hit3};
  end

  // multiply stage: |d| * q
  localparam int LI = T_FRAC_BITS + 2;
  logic hm;
  logic [MW-1:0] mx, my;
  logic sx, sy;
  logic signed [CW-1:0] max, may;
  always_ff @(posedge clk) begin
    if (adv) begin
      hm  <= hh[T_FRAC_BITS-1];
      sx  <= cdx[LI][DW-1];
      sy  <= cdy[LI][DW-1];
      mx  <= MW'(qq[T_FRAC_BITS]) * MW'(cdx[LI][DW-1] ? -cdx[LI] : cdx[LI]);
      my  <= MW'(qq[T_FRAC_BITS]) * MW'(cdy[LI][DW-1] ? -cdy[LI] : cdy[LI]);
      max <= cax[LI];
      may <= cay[LI];
    end
  end

  // output stage
  logic [DW-1:0] tx, ty;
  always_comb begin
    tx = mx[MW-1:T_FRAC_BITS];
    ty = my[MW-1:T_FRAC_BITS];
    if (sx) tx = -tx;
    if (sy) ty = -ty;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      out_data.hit   <= hm;
      out_data.hit_x <= hm ? CW'(max + CW'(tx)) : '0;
      out_data.hit_y <= hm ? CW'(may + CW'(ty)) : '0;
    end
  end
endmodule
`default_nettype wire

// File: hw/rtl/sip_area.sv
`default_nettype none
// Registered doubled triangle areas a1, a2, a3 with a4 derived; two stages.
module sip_area #(
  parameter int CW = 24
) (
  input  wire logic                 clk,
  input  wire logic                 adv,
  input  wire logic signed [CW-1:0] ax, ay, bx, by, cx, cy, dx, dy,
  output logic signed [2*CW+3:0]    a1, a2, a3, a4
);
  localparam int DW = CW + 1;
  localparam int PW = 2 * DW;
  localparam int AW = 2 * CW + 4;

  logic signed [DW-1:0] e0, e1, e2, e3, f0, f1, f2, f3, g0, g1, g2, g3;
  logic signed [PW-1:0] p0, p1, p2, p3, p4, p5;
  logic signed [AW-1:0] s1, s2, s3;

  always_comb begin
    e0 = DW'(ax) - DW'(dx); e1 = DW'(by) - DW'(dy);
    e2 = DW'(ay) - DW'(dy); e3 = DW'(bx) - DW'(dx);
    f0 = DW'(ax) - DW'(cx); f1 = DW'(by) - DW'(cy);
    f2 = DW'(ay) - DW'(cy); f3 = DW'(bx) - DW'(cx);
    g0 = DW'(cx) - DW'(ax); g1 = DW'(dy) - DW'(ay);
    g2 = DW'(cy) - DW'(ay); g3 = DW'(dx) - DW'(ax);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p0 <= e0 * e1; p1 <= e2 * e3;
      p2 <= f0 * f1; p3 <= f2 * f3;
      p4 <= g0 * g1; p5 <= g2 * g3;
    end
  end

  always_comb begin
    s1 = AW'(p0) - AW'(p1);
    s2 = AW'(p2) - AW'(p3);
    s3 = AW'(p4) - AW'(p5);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a1 <= s1; a2 <= s2; a3 <= s3;
      a4 <= s3 + s2 - s1;
    end
  end
endmodule
`default_nettype wire

// File: hw/rtl/sip_div_stage.sv
`default_nettype none
// One restoring-division step per stage: shift, compare, subtract.
module sip_div_stage #(
  parameter int NW = 52,
  parameter int QW = 16
) (
  input  wire logic          clk,
  input  wire logic          adv,
  input  wire logic [NW-1:0] num_in,
  input  wire logic [NW-1:0] den_in,
  input  wire logic [QW-1:0] q_in,
  output logic      [NW-1:0] num_out,
  output logic      [NW-1:0] den_out,
  output logic      [QW-1:0] q_out
);
  logic [NW:0] sh;
  logic        ge;

  always_comb begin
    sh = {num_in, 1'b0};
    ge = sh >= {1'b0, den_in};
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      num_out <= ge ? NW'(sh - {1'b0, den_in}) : sh[NW-1:0];
      den_out <= den_in;
      q_out   <= {q_in[QW-2:0], ge};
    end
  end
endmodule
`default_nettype wire

// File: tb/sv/testbench.sv
module testbench;
  import sip_pkg::*;

  localparam int Latency = 6 + TFracBits;
  localparam int HoldCycles = 200;

  logic     clk = 1'b0;
  logic     rst = 1'b1;
  logic     in_valid = 1'b0;
  logic     in_stall;
  seg_in_t  in_data = '0;
  logic     out_valid;
  logic     out_stall = 1'b0;
  seg_out_t out_data;

  seg_in_t  pending_pairs[$];
  seg_out_t expected_points[$];
  int       errors = 0;
  int       hits_seen = 0;
  int       results_seen = 0;
  bit       hold_receiver = 0;
  int       hold_left = 0;
  bit       sent = 0;
  int       send_gap = 0;
  int       recv_gap = 0;

  segment_intersection_point uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  always #10 clk = ~clk;

  // doubled signed area of triangle p,q,r
  function automatic logic signed [127:0] tri_area(
      logic signed [127:0] px, py, qx, qy, rx, ry);
    return (px - rx) * (qy - ry) - (py - ry) * (qx - rx);
  endfunction

  function automatic bit strictly_opposite(logic signed [127:0] a, b);
    return a != 0 && b != 0 && (a[127] != b[127]);
  endfunction

  // trunc(t*d) toward zero
  function automatic logic signed [127:0] scale_toward_zero(
      logic [127:0] t, logic signed [127:0] d);
    logic [127:0] mag;
    mag = ((d < 0) ? -d : d) * t;
    mag = mag >> TFracBits;
    return (d < 0) ? -$signed(mag) : $signed(mag);
  endfunction

  function automatic seg_out_t crossing_point(seg_in_t s);
    logic signed [127:0] ax, ay, bx, by, cx, cy, dx, dy;
    logic signed [127:0] a1, a2, a3, a4;
    logic [127:0] num, den, q;
    seg_out_t r;
    ax = 128'(s.seg1_start_x); ay = 128'(s.seg1_start_y);
    bx = 128'(s.seg1_end_x);   by = 128'(s.seg1_end_y);
    cx = 128'(s.seg2_start_x); cy = 128'(s.seg2_start_y);
    dx = 128'(s.seg2_end_x);   dy = 128'(s.seg2_end_y);
    r = '0;
    a1 = tri_area(ax, ay, bx, by, dx, dy);
    a2 = tri_area(ax, ay, bx, by, cx, cy);
    a3 = tri_area(cx, cy, dx, dy, ax, ay);
    a4 = a3 + a2 - a1;
    if (!strictly_opposite(a1, a2) || !strictly_opposite(a3, a4)) return r;
    num = (a3 < 0) ? -a3 : a3;
    den = ((a3 - a4) < 0) ? -(a3 - a4) : (a3 - a4);
    q = (num << TFracBits) / den;
    r.hit = 1'b1;
    r.hit_x = CoordWidth'(ax + scale_toward_zero(q, bx - ax));
    r.hit_y = CoordWidth'(ay + scale_toward_zero(q, by - ay));
    return r;
  endfunction

  function automatic logic [CoordWidth-1:0] rand_coord();
    case ($urandom_range(0, 5))
      0: return {1'b1, {(CoordWidth-1){1'b0}}};
      1: return {1'b0, {(CoordWidth-1){1'b1}}};
      2: return CoordWidth'(int'($urandom_range(0, 64)) - 32);
      default: return CoordWidth'($urandom);
    endcase
  endfunction

  function automatic int rand_gap();
    if ($urandom_range(0, 19) == 0) return $urandom_range(10, 40);
    if ($urandom_range(0, 2) == 0) return 0;
    return $urandom_range(0, 3);
  endfunction

  // crossing pair built around a chosen center so most random items hit
  function automatic seg_in_t crossing_pair(int span);
    seg_in_t s;
    int cx, cy;
    cx = $signed($urandom) >>> 9;
    cy = $signed($urandom) >>> 9;
    s.seg1_start_x = CoordWidth'(cx - int'($urandom_range(1, span)));
    s.seg1_start_y = CoordWidth'(cy - int'($urandom_range(0, span)) + span / 2);
    s.seg1_end_x   = CoordWidth'(cx + int'($urandom_range(1, span)));
    s.seg1_end_y   = CoordWidth'(cy + int'($urandom_range(0, span)) - span / 2);
    s.seg2_start_x = CoordWidth'(cx + int'($urandom_range(0, span)) - span / 2);
    s.seg2_start_y = CoordWidth'(cy - int'($urandom_range(1, span)));
    s.seg2_end_x   = CoordWidth'(cx + int'($urandom_range(0, span)) - span / 2);
    s.seg2_end_y   = CoordWidth'(cy + int'($urandom_range(1, span)));
    if ($urandom_range(0, 1)) begin
      s.seg1_start_x = s.seg1_end_x;
      s.seg1_end_x = CoordWidth'(cx - int'($urandom_range(1, span)));
    end
    return s;
  endfunction

  function automatic seg_in_t make_pair(int x0, y0, x1, y1, x2, y2, x3, y3);
    seg_in_t s;
    s.seg1_start_x = CoordWidth'(x0); s.seg1_start_y = CoordWidth'(y0);
    s.seg1_end_x   = CoordWidth'(x1); s.seg1_end_y   = CoordWidth'(y1);
    s.seg2_start_x = CoordWidth'(x2); s.seg2_start_y = CoordWidth'(y2);
    s.seg2_end_x   = CoordWidth'(x3); s.seg2_end_y   = CoordWidth'(y3);
    return s;
  endfunction

  // input transfer: record it at the accepting edge
  always @(posedge clk) begin
    sent = 1'b0;
    if (!rst && in_valid && !in_stall) begin
      expected_points.push_back(crossing_point(in_data));
      void'(pending_pairs.pop_front());
      sent = 1'b1;
    end
  end

  // driver: hold a stalled item, otherwise advance
  always @(negedge clk) begin
    if (!rst && (sent || !in_valid)) begin
      if (sent) send_gap = rand_gap();
      if (send_gap > 0) begin
        send_gap--;
        in_valid <= 1'b0;
      end else if (pending_pairs.size() > 0) begin
        in_valid <= 1'b1;
        in_data <= pending_pairs[0];
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver stall
  always @(negedge clk) begin
    if (!rst) begin
      if (hold_receiver && hold_left < HoldCycles) begin
        hold_left++;
        out_stall <= 1'b1;
      end else if (recv_gap > 0) begin
        recv_gap--;
        out_stall <= 1'b1;
      end else begin
        recv_gap = rand_gap();
        out_stall <= (recv_gap > 0);
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    seg_out_t exp_pt;
    if (!rst && out_valid && !out_stall) begin
      results_seen++;
      if (expected_points.size() == 0) begin
        $error("result with no pending pair");
        errors++;
      end else begin
        exp_pt = expected_points.pop_front();
        if (exp_pt.hit) hits_seen++;
        if (out_data.hit !== exp_pt.hit) begin
          $error("hit: expected %0d actual %0d", exp_pt.hit, out_data.hit);
          errors++;
        end
        if (out_data.hit_x !== exp_pt.hit_x) begin
          $error("hit_x: expected %0d actual %0d", exp_pt.hit_x, out_data.hit_x);
          errors++;
        end
        if (out_data.hit_y !== exp_pt.hit_y) begin
          $error("hit_y: expected %0d actual %0d", exp_pt.hit_y, out_data.hit_y);
          errors++;
        end
      end
    end
  end

  initial begin
    #20000000;
    $display("status: fail");
    $finish;
  end

  task automatic wait_drained();
    while (pending_pairs.size() > 0 || in_valid || expected_points.size() > 0)
      @(posedge clk);
  endtask

  initial begin
    seg_in_t s;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // plain cross, touching, collinear, degenerate, parallel, extremes
    pending_pairs.push_back(make_pair(0, 0, 512, 512, 0, 512, 512, 0));
    pending_pairs.push_back(make_pair(0, 0, 256, 0, 128, 0, 128, 256));
    pending_pairs.push_back(make_pair(0, 0, 256, 256, 512, 512, 768, 768));
    pending_pairs.push_back(make_pair(5, 5, 5, 5, 0, 0, 10, 10));
    pending_pairs.push_back(make_pair(0, 0, 256, 0, 0, 10, 256, 10));
    pending_pairs.push_back(make_pair(-8388608, -8388608, 8388607, 8388607,
                                      -8388608, 8388607, 8388607, -8388608));
    pending_pairs.push_back(make_pair(8388607, -8388608, -8388608, 8388607,
                                      -8388608, -8388608, 8388607, 8388607));
    pending_pairs.push_back(make_pair(-8388608, 0, 8388607, 1,
                                      0, -8388608, 1, 8388607));
    pending_pairs.push_back(make_pair(0, 0, 3, 1, 0, 1, 3, 0));
    pending_pairs.push_back(make_pair(-1, -1, 1, 1, -1, 1, 1, -1));
    pending_pairs.push_back(make_pair(0, 0, 100, 0, 50, -1, 50, -100));
    pending_pairs.push_back(make_pair(0, 0, 0, 0, 0, 0, 0, 0));
    pending_pairs.push_back(make_pair(-1, -1, -1, -1, -1, -1, -1, -1));
    wait_drained();

    // long receiver hold while the sender keeps offering
    hold_left = 0;
    hold_receiver = 1;
    for (int i = 0; i < 60; i++) pending_pairs.push_back(crossing_pair(4096));
    wait (hold_left == HoldCycles);
    hold_receiver = 0;
    wait_drained();

    for (int i = 0; i < 440; i++) begin
      if (i % 5 == 4) begin
        for (int k = 0; k < 8; k++) s[k*CoordWidth +: CoordWidth] = rand_coord();
        pending_pairs.push_back(s);
      end else begin
        pending_pairs.push_back(crossing_pair(i % 40 == 0 ? 4000000 : 1 << ($urandom_range(1, 16))));
      end
    end
    wait_drained();
    repeat (Latency + 10) @(posedge clk);

    $display("ran %0d segment pairs, %0d crossings; touching, collinear,", results_seen, hits_seen);
    $display("degenerate and full-range coordinates included, with stalls on both sides");
    if (errors == 0 && expected_points.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule
